// ----- src/pbt_pkg.sv -----
// Package for the Poisson-binomial tie probability block.
// Fixed-point types, constants and the cell control struct.
// No dependencies.
package pbt_pkg;

  localparam int PROB_W     = 17;
  localparam int DIST_W     = 33;
  localparam int PROD_W     = PROB_W + DIST_W;
  localparam int FRAC_W     = 16;
  localparam int SEEN_W     = 7;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  typedef logic [PROB_W-1:0] prob_t;
  typedef logic [DIST_W-1:0] dist_t;

  localparam prob_t ONE_Q16 = 17'h1_0000;
  localparam dist_t ONE_Q32 = 33'h1_0000_0000;

  typedef struct packed {
    logic  fold;
    logic  clear;
    prob_t p;
    prob_t q;
  } cell_ctrl_t;

endpackage

// ----- src/pbt_cell.sv -----
// One distribution entry: dist' = trunc(dist*q) + trunc(left*p), saturated at 1.0.
// Depends on pbt_pkg.
module pbt_cell #(
  parameter bit RESET_ONE = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pbt_pkg::cell_ctrl_t ctrl,
  input  pbt_pkg::dist_t     left_in,
  output pbt_pkg::dist_t     val
);

  localparam pbt_pkg::dist_t RST_VAL = RESET_ONE ? pbt_pkg::ONE_Q32 : '0;
  localparam int SUM_W = pbt_pkg::PROD_W - pbt_pkg::FRAC_W + 1;

  pbt_pkg::dist_t              val_r;
  pbt_pkg::dist_t              val_nxt;
  logic [pbt_pkg::PROD_W-1:0]  stay_prod;
  logic [pbt_pkg::PROD_W-1:0]  move_prod;
  logic [SUM_W-1:0]            sum;

  assign stay_prod = {{pbt_pkg::PROB_W{1'b0}}, val_r} *
                     {{pbt_pkg::DIST_W{1'b0}}, ctrl.q};
  assign move_prod = {{pbt_pkg::PROB_W{1'b0}}, left_in} *
                     {{pbt_pkg::DIST_W{1'b0}}, ctrl.p};
  assign sum = {1'b0, stay_prod[pbt_pkg::PROD_W-1:pbt_pkg::FRAC_W]} +
               {1'b0, move_prod[pbt_pkg::PROD_W-1:pbt_pkg::FRAC_W]};

  always_comb begin
    if (sum > SUM_W'(pbt_pkg::ONE_Q32)) begin
      val_nxt = pbt_pkg::ONE_Q32;
    end else begin
      val_nxt = sum[pbt_pkg::DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= RST_VAL;
    end else if (ctrl.clear) begin
      val_r <= RST_VAL;
    end else if (ctrl.fold) begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

// ----- src/pbt_chain.sv -----
// Row of MAX_N+1 cells, each above cell 0 fed by its lower neighbor, plus the tie-entry readout.
// Depends on pbt_pkg and pbt_cell.
module pbt_chain #(
  parameter int MAX_N = 64,
  parameter int CW    = $clog2(MAX_N + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pbt_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       sel,
  output pbt_pkg::dist_t      sel_val
);

  pbt_pkg::dist_t vals [MAX_N+1];
  pbt_pkg::dist_t lefts [MAX_N+1];

  assign lefts[0] = '0;

  for (genvar j = 0; j <= MAX_N; j++) begin : g_cell
    if (j > 0) begin : g_link
      assign lefts[j] = vals[j-1];
    end
    pbt_cell #(
      .RESET_ONE(j == 0)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .left_in(lefts[j]),
      .val    (vals[j])
    );
  end

  // tie index never exceeds MAX_N/2
  always_comb begin
    sel_val = '0;
    for (int j = 0; j <= MAX_N / 2; j++) begin
      if (sel == CW'(j)) begin
        sel_val = sel_val | vals[j];
      end
    end
  end

endmodule

// ----- src/poisson_binomial_tie_probability.sv -----
// An in_tlast beat sets the pending flag; the result is then captured into the
// output registers once the previous result, if any, is taken, and out_tvalid rises.
// Throughput: one probability per cycle, except that in_tready is low while pending.
// Each probability accepted while fewer than MAX_N are counted updates all MAX_N+1 cells in parallel.
// Reset: synchronous, rst_n low; distribution to 1.0 at zero successes, count
// and overflow cleared, no result pending.
module poisson_binomial_tie_probability #(
  parameter int MAX_N = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pbt_pkg::IN_DATA_W-1:0]      in_tdata,   // [16:0] prob
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pbt_pkg::OUT_DATA_W-1:0]     out_tdata,  // [32:0] tie_prob, [39:33] items_seen
  output logic                               out_tuser   // [0] overflow
);

  localparam int CW = $clog2(MAX_N + 1);

  logic                 pend_r;
  logic                 pend_nxt;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic                 excess_r;
  logic                 excess_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  pbt_pkg::dist_t       out_tie_r;
  logic [pbt_pkg::SEEN_W-1:0] out_seen_r;
  logic                 out_ovf_r;

  logic                 in_acc;
  logic                 room;
  logic                 capture;
  pbt_pkg::prob_t       prob;
  pbt_pkg::prob_t       p_sat;
  pbt_pkg::cell_ctrl_t  ctrl;
  pbt_pkg::dist_t       tie_val;
  logic [CW+pbt_pkg::SEEN_W-1:0] count_ext;

  assign prob      = in_tdata[pbt_pkg::PROB_W-1:0];
  assign p_sat     = (prob > pbt_pkg::ONE_Q16) ? pbt_pkg::ONE_Q16 : prob;
  assign in_tready = !pend_r;
  assign in_acc    = in_tvalid && in_tready;
  assign room      = (count_r != CW'(MAX_N));
  assign capture   = pend_r && (!out_valid_r || out_tready);

  assign ctrl.fold  = in_acc && room;
  assign ctrl.clear = capture;
  assign ctrl.p     = p_sat;
  assign ctrl.q     = pbt_pkg::ONE_Q16 - p_sat;

  pbt_chain #(
    .MAX_N(MAX_N),
    .CW   (CW)
  ) u_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (ctrl),
    .sel    (count_r >> 1),
    .sel_val(tie_val)
  );

  always_comb begin
    pend_nxt   = pend_r;
    count_nxt  = count_r;
    excess_nxt = excess_r;
    if (capture) begin
      pend_nxt   = 1'b0;
      count_nxt  = '0;
      excess_nxt = 1'b0;
    end else if (in_acc) begin
      if (room) begin
        count_nxt = count_r + CW'(1);
      end else begin
        excess_nxt = 1'b1;
      end
      pend_nxt = in_tlast;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (capture) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign count_ext = {{pbt_pkg::SEEN_W{1'b0}}, count_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      count_r     <= '0;
      excess_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      excess_r    <= excess_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      out_tie_r  <= tie_val;
      out_seen_r <= count_ext[pbt_pkg::SEEN_W-1:0];
      out_ovf_r  <= excess_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_seen_r, out_tie_r};
  assign out_tuser  = out_ovf_r;

endmodule

// ----- src/pbt_checker.sv -----
// Port-level checks for the Poisson-binomial tie probability block.
// Depends on pbt_pkg; bound to poisson_binomial_tie_probability.
module pbt_checker #(
  parameter int MAX_N = 64
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           in_tlast,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [pbt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tuser
);

  localparam int SEEN_LO = pbt_pkg::DIST_W;
  localparam int SEEN_HI = pbt_pkg::DIST_W + pbt_pkg::SEEN_W - 1;
  localparam logic [pbt_pkg::SEEN_W-1:0] MAX_SEEN = pbt_pkg::SEEN_W'(MAX_N);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  a_tie_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[pbt_pkg::DIST_W-1] && (|out_tdata[pbt_pkg::DIST_W-2:0])))
    else $error("tie probability above 1.0");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[SEEN_HI:SEEN_LO] == MAX_SEEN)
    else $error("overflow flagged without a full count");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input taken in the cycle after a last beat");

endmodule

bind poisson_binomial_tie_probability pbt_checker #(
  .MAX_N(MAX_N)
) u_pbt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tlast  (in_tlast),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);
